FILE: rtl/core/bfrd_pkg.sv
// Shared types and constants for the bounded command FIFO with reject on full.
// Used by bounded_fifo_reject_drain; depends on nothing else.
`default_nettype none

package bfrd_pkg;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned TOT_W  = 32;
  localparam int unsigned PORT_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic              push_accepted;
    logic              has_command;
    logic [PORT_W-1:0] drained_word;
    logic              last_of_run;
    logic [CNT_W-1:0]  occupancy;
    logic [CNT_W-1:0]  peak_occupancy;
    logic [TOT_W-1:0]  accepted_total;
    logic [TOT_W-1:0]  rejected_total;
    logic [TOT_W-1:0]  drained_total;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; instantiated by bounded_fifo_reject_drain.
`default_nettype none

module bfrd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/bounded_fifo_reject_drain.sv
// Bounded command FIFO with reject on full and whole-queue drain.
// A push or an empty drain yields one result beat, registered and shown in the cycle after start.
// A drain of N entries keeps busy high while it runs and yields N beats, one per cycle,
// paced by the registered read port of the entry RAM.
// The result strobe cannot be stalled. Synchronous reset clears pointers, counts, counters
// and sets the capacity to 64; the entry RAM is not cleared. Depends on bfrd_pkg, bfrd_ram.
`default_nettype none

module bounded_fifo_reject_drain #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_kind,
  input  wire logic [bfrd_pkg::PORT_W-1:0]      in_command_word,
  output logic                                  out_valid,
  output logic                                  out_push_accepted,
  output logic                                  out_has_command,
  output logic      [bfrd_pkg::PORT_W-1:0]      out_drained_word,
  output logic                                  out_last_of_run,
  output logic      [bfrd_pkg::CNT_W-1:0]       out_occupancy,
  output logic      [bfrd_pkg::CNT_W-1:0]       out_peak_occupancy,
  output logic      [bfrd_pkg::TOT_W-1:0]       out_accepted_total,
  output logic      [bfrd_pkg::TOT_W-1:0]       out_rejected_total,
  output logic      [bfrd_pkg::TOT_W-1:0]       out_drained_total,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bfrd_pkg::CNT_W-1:0]       cfg_capacity_limit
);

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned STORE_W = (WORD_WIDTH < bfrd_pkg::PORT_W) ? WORD_WIDTH
                                                                   : bfrd_pkg::PORT_W;
  localparam logic [bfrd_pkg::CNT_W-1:0] DEPTH_C = bfrd_pkg::CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]           LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [0:0] {ST_IDLE, ST_DRAIN} state_t;

  state_t                        state_r, state_nxt;
  logic [PTR_W-1:0]              head_r, head_nxt;
  logic [PTR_W-1:0]              tail_r, tail_nxt;
  logic [bfrd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [bfrd_pkg::CNT_W-1:0]    peak_r, peak_nxt;
  logic [bfrd_pkg::TOT_W-1:0]    acc_r, acc_nxt;
  logic [bfrd_pkg::TOT_W-1:0]    rej_r, rej_nxt;
  logic [bfrd_pkg::TOT_W-1:0]    drn_r, drn_nxt;
  logic [bfrd_pkg::CNT_W-1:0]    cap_r, cap_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bfrd_pkg::result_t             out_r, out_nxt;

  logic [bfrd_pkg::CNT_W-1:0]    cap_eff;
  logic                          in_take;
  logic                          wr_en;
  logic [STORE_W-1:0]            rd_data;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_P) ? '0 : p + 1'b1;
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign in_take   = start && !busy;
  assign cfg_ready = 1'b1;
  assign cap_eff   = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;

  bfrd_ram #(
    .WIDTH (STORE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (STORE_W'(in_command_word)),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    peak_nxt      = peak_r;
    acc_nxt       = acc_r;
    rej_nxt       = rej_r;
    drn_nxt       = drn_r;
    cap_nxt       = (cfg_valid && cfg_ready) ? cfg_capacity_limit : cap_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          out_nxt.push_accepted = 1'b0;
          out_nxt.has_command   = 1'b0;
          out_nxt.drained_word  = '0;
          out_nxt.last_of_run   = 1'b1;
          if (in_kind == bfrd_pkg::KIND_PUSH) begin
            out_valid_nxt = 1'b1;
            if (count_r < cap_eff) begin
              wr_en     = 1'b1;
              tail_nxt  = ptr_inc(tail_r);
              count_nxt = count_r + 1'b1;
              acc_nxt   = acc_r + 1'b1;
              if (count_nxt > peak_r) begin
                peak_nxt = count_nxt;
              end
              out_nxt.push_accepted = 1'b1;
            end else begin
              rej_nxt = rej_r + 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        head_nxt              = ptr_inc(head_r);
        count_nxt             = count_r - 1'b1;
        drn_nxt               = drn_r + 1'b1;
        out_valid_nxt         = 1'b1;
        out_nxt.push_accepted = 1'b0;
        out_nxt.has_command   = 1'b1;
        out_nxt.drained_word  = bfrd_pkg::PORT_W'(rd_data);
        out_nxt.last_of_run   = (count_r == 7'd1);
        if (count_r == 7'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_nxt.occupancy      = count_nxt;
    out_nxt.peak_occupancy = peak_nxt;
    out_nxt.accepted_total = acc_nxt;
    out_nxt.rejected_total = rej_nxt;
    out_nxt.drained_total  = drn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      peak_r      <= '0;
      acc_r       <= '0;
      rej_r       <= '0;
      drn_r       <= '0;
      cap_r       <= bfrd_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      peak_r      <= peak_nxt;
      acc_r       <= acc_nxt;
      rej_r       <= rej_nxt;
      drn_r       <= drn_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_push_accepted  = out_r.push_accepted;
  assign out_has_command    = out_r.has_command;
  assign out_drained_word   = out_r.drained_word;
  assign out_last_of_run    = out_r.last_of_run;
  assign out_occupancy      = out_r.occupancy;
  assign out_peak_occupancy = out_r.peak_occupancy;
  assign out_accepted_total = out_r.accepted_total;
  assign out_rejected_total = out_r.rejected_total;
  assign out_drained_total  = out_r.drained_total;

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("Drain state entered with an empty queue.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= DEPTH_C) && (peak_r >= count_r))
    else $error("Occupancy exceeds depth or watermark.");

  a_push_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_kind == bfrd_pkg::KIND_PUSH)) |=> (out_valid_r && out_r.last_of_run))
    else $error("Push did not produce a single result beat.");

  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.has_command) |-> (out_r.last_of_run == (out_r.occupancy == '0)))
    else $error("Drain last mark disagrees with occupancy.");

  a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r == '0) |-> (head_r == tail_r))
    else $error("Head and tail pointers differ on an empty queue.");

endmodule

`default_nettype wire
